// ===== design/mskn_pkg.sv =====
// Package for the multichannel scalar Kalman normalizer: shared widths,
// register indexes, channel classes, controller states and command structs.
// No dependencies.
package mskn_pkg;

    localparam int DEF_NUM_CHANNELS = 8;
    localparam int DEF_FRAC_BITS    = 16;

    localparam int CHANNEL_W   = 3;
    localparam int DATA_W      = 32;
    localparam int CFG_ADDR_W  = 1;
    localparam int NORM_MUL_W  = 11;

    // Normalization constants per channel class.
    localparam int TEMP_SCALE   = 1000;
    localparam int ACCEL_SCALE  = 125;
    localparam int GYRO_SCALE   = 2;
    localparam int LIGHT_SCALE  = 1000;
    localparam int ACCEL_OFFSET = 4;
    localparam int GYRO_OFFSET  = 250;
    localparam int LIGHT_SHIFT  = 10;

    localparam logic [CHANNEL_W-1:0] CH_TEMP       = 3'd0;
    localparam logic [CHANNEL_W-1:0] CH_ACCEL_LAST = 3'd3;
    localparam logic [CHANNEL_W-1:0] CH_GYRO_LAST  = 3'd6;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PROCESS_NOISE_Q     = 1'b0,
        CFG_MEASUREMENT_NOISE_R = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_TEMP,
        KIND_ACCEL,
        KIND_GYRO,
        KIND_LIGHT
    } chan_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_MUL,
        ST_UPDATE,
        ST_NORM,
        ST_DONE
    } mskn_state_t;

    typedef struct packed {
        logic capture;
        logic load;
        logic div_step;
        logic mul;
        logic update;
        logic norm;
        logic finish;
    } mskn_cmd_t;

    typedef struct packed {
        logic div_done;
    } mskn_status_t;

    function automatic chan_kind_t chan_kind(input logic [CHANNEL_W-1:0] ch);
        chan_kind_t kind;
        if (ch == CH_TEMP)
            kind = KIND_TEMP;
        else if (ch <= CH_ACCEL_LAST)
            kind = KIND_ACCEL;
        else if (ch <= CH_GYRO_LAST)
            kind = KIND_GYRO;
        else
            kind = KIND_LIGHT;
        return kind;
    endfunction

endpackage

// ===== design/multichannel_scalar_kalman_normalizer_unit.sv =====
// One word is processed at a time: a new input word is taken only after the last
// one has reached the output register. The restoring gain divider produces
// one quotient bit per cycle.
// A finished word waits in the output register while the next input is taken.
// Reset (asynchronous, active low): Q = 1.0, R = 0.1, every estimate 0, every
// covariance 1.0, output register empty. Top level; depends on mskn_pkg, mskn_ctrl, mskn_datapath.
module multichannel_scalar_kalman_normalizer_unit
    import mskn_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int FRAC_BITS    = DEF_FRAC_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [31:0]             s_axis_tdata,   // [31:0] sample
    input  logic [2:0]              s_axis_tuser,   // [2:0] channel
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [63:0]             m_axis_tdata,   // [31:0] estimate, [63:32] normalized
    output logic [3:0]              m_axis_tuser,   // [2:0] out_channel, [3] saturated
    input  logic                    cfg_we,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [DATA_W-1:0]       cfg_wdata
);

    mskn_cmd_t            cmd;
    mskn_status_t         status;
    logic [CHANNEL_W-1:0] out_channel;
    logic [DATA_W-1:0]    out_estimate;
    logic [DATA_W-1:0]    out_normalized;
    logic                 out_saturated;

    mskn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    mskn_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .in_channel     (s_axis_tuser),
        .in_sample      (s_axis_tdata),
        .cmd            (cmd),
        .status         (status),
        .out_channel    (out_channel),
        .out_estimate   (out_estimate),
        .out_normalized (out_normalized),
        .out_saturated  (out_saturated)
    );

    assign m_axis_tdata = {out_normalized, out_estimate};
    assign m_axis_tuser = {out_saturated, out_channel};

endmodule

// ===== design/mskn_ctrl.sv =====
// Controller of the Kalman normalizer: sequences one word through load,
// divide, multiply, update, normalize and output. Depends on mskn_pkg.
module mskn_ctrl
    import mskn_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  mskn_status_t status,
    output mskn_cmd_t    cmd
);

    mskn_state_t state_reg;
    mskn_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    // The output register can take a new word when empty or being drained.
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_LOAD;
            end
            ST_LOAD:   state_next = ST_DIV;
            ST_DIV:
            begin
                if (status.div_done)
                    state_next = ST_MUL;
            end
            ST_MUL:    state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_NORM;
            ST_NORM:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_LOAD:   cmd.load = 1'b1;
            ST_DIV:    cmd.div_step = !status.div_done;
            ST_MUL:    cmd.mul = 1'b1;
            ST_UPDATE: cmd.update = 1'b1;
            ST_NORM:   cmd.norm = 1'b1;
            ST_DONE:   cmd.finish = out_free;
            default:   cmd = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== design/mskn_datapath.sv =====
// Datapath of the Kalman normalizer: noise registers, per-channel state,
// restoring gain divider, update multipliers and normalization. Depends on mskn_pkg.
module mskn_datapath
    import mskn_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int FRAC_BITS    = DEF_FRAC_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [DATA_W-1:0]       cfg_wdata,
    input  logic [CHANNEL_W-1:0]    in_channel,
    input  logic [DATA_W-1:0]       in_sample,
    input  mskn_cmd_t               cmd,
    output mskn_status_t            status,
    output logic [CHANNEL_W-1:0]    out_channel,
    output logic [DATA_W-1:0]       out_estimate,
    output logic [DATA_W-1:0]       out_normalized,
    output logic                    out_saturated
);

    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CMP_W  = 5;
    localparam int K_W    = FRAC_BITS + 1;
    localparam int CNT_W  = $clog2(K_W + 1);
    localparam int DEN_W  = DATA_W + 1;
    localparam int REM_W  = DATA_W + 2;
    localparam int DIFF_W = DATA_W + 1;
    localparam int PE_W   = DIFF_W + K_W + 1;
    localparam int PP_W   = DATA_W + K_W;
    localparam int NV_W   = DATA_W + 2;
    localparam int NP_W   = NV_W + NORM_MUL_W;

    localparam logic [DATA_W-1:0] ONE_FX  = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic [DATA_W-1:0] R_RESET = DATA_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [K_W-1:0]    K_ONE   = K_W'(64'd1 << FRAC_BITS);
    localparam logic signed [NV_W-1:0] ACCEL_OFF = NV_W'(64'(ACCEL_OFFSET) << FRAC_BITS);
    localparam logic signed [NV_W-1:0] GYRO_OFF  = NV_W'(64'(GYRO_OFFSET) << FRAC_BITS);
    localparam logic signed [NP_W-1:0] BIAS_STD  = NP_W'((65'd1 << FRAC_BITS) - 65'd1);
    localparam logic signed [NP_W-1:0] BIAS_LIGHT =
        NP_W'((65'd1 << (FRAC_BITS + LIGHT_SHIFT)) - 65'd1);
    localparam logic signed [NP_W-1:0] NORM_MAX =
        {{(NP_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam logic signed [NP_W-1:0] NORM_MIN = ~NORM_MAX;

    // Configuration registers.
    logic [DATA_W-1:0] q_reg;
    logic [DATA_W-1:0] r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= ONE_FX;
            r_reg <= R_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                CFG_PROCESS_NOISE_Q:     q_reg <= cfg_wdata;
                CFG_MEASUREMENT_NOISE_R: r_reg <= cfg_wdata;
                default:                 q_reg <= q_reg;
            endcase
        end
    end

    // Per-channel state.
    logic [DATA_W-1:0] est_mem_reg [NUM_CHANNELS];
    logic [DATA_W-1:0] cov_mem_reg [NUM_CHANNELS];

    logic [CHANNEL_W-1:0]     ch_reg;
    logic [DATA_W-1:0]        sample_reg;
    logic [DATA_W-1:0]        est_reg;
    logic [DATA_W-1:0]        p_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [K_W-1:0]           quo_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [PE_W-1:0]   prod_e_reg;
    logic [PP_W-1:0]          prod_p_reg;
    logic [DATA_W-1:0]        est_new_reg;
    logic signed [NP_W-1:0]   nprod_reg;

    logic [CHANNEL_W-1:0]     out_channel_reg;
    logic [DATA_W-1:0]        out_estimate_reg;
    logic [DATA_W-1:0]        out_normalized_reg;
    logic                     out_saturated_reg;

    logic                     ch_ok;
    logic [CH_W-1:0]          idx;
    chan_kind_t               kind;

    assign ch_ok = CMP_W'(ch_reg) < CMP_W'(NUM_CHANNELS);
    assign idx   = CH_W'(ch_reg);
    assign kind  = chan_kind(ch_reg);

    // Load: covariance plus Q, saturated to 32 bits, and the gain denominator.
    logic [DATA_W-1:0] est_rd;
    logic [DATA_W-1:0] cov_rd;
    logic [DATA_W:0]   p_sum;
    logic [DATA_W-1:0] p_sat;
    logic [DEN_W-1:0]  den_sum;

    assign est_rd  = ch_ok ? est_mem_reg[idx] : '0;
    assign cov_rd  = ch_ok ? cov_mem_reg[idx] : '0;
    assign p_sum   = {1'b0, cov_rd} + {1'b0, q_reg};
    assign p_sat   = p_sum[DATA_W] ? '1 : p_sum[DATA_W-1:0];
    assign den_sum = {1'b0, p_sat} + {1'b0, r_reg};

    // Restoring division: the first step yields the integer bit, the rest
    // yield one fraction bit each, FRAC_BITS + 1 steps in all.
    logic [REM_W-1:0] trial;
    logic             trial_ge;

    assign trial    = (cnt_reg == '0) ? rem_reg : {rem_reg[REM_W-2:0], 1'b0};
    assign trial_ge = trial >= REM_W'(den_reg);
    assign status.div_done = cnt_reg == CNT_W'(K_W);

    // Gain and update products. A zero denominator forces a zero gain.
    logic [K_W-1:0]           gain;
    logic signed [DIFF_W-1:0] diff_s;
    logic signed [K_W:0]      gain_s;
    logic signed [PE_W-1:0]   shifted;
    logic [DATA_W-1:0]        est_new;

    assign gain    = (den_reg == '0) ? '0 : quo_reg;
    assign diff_s  = $signed({sample_reg[DATA_W-1], sample_reg})
                   - $signed({est_reg[DATA_W-1], est_reg});
    assign gain_s  = $signed({1'b0, gain});
    assign shifted = prod_e_reg >>> FRAC_BITS;
    assign est_new = est_reg + shifted[DATA_W-1:0];

    // Normalization: offset, constant scale, truncation toward zero, clamp.
    logic signed [NV_W-1:0]       norm_off;
    logic signed [NORM_MUL_W-1:0] norm_scale;
    logic signed [NV_W-1:0]       norm_v;
    logic signed [NP_W-1:0]       biased;
    logic signed [NP_W-1:0]       norm_q;
    logic                         sat_hi;
    logic                         sat_lo;

    always_comb
    begin
        unique case (kind)
            KIND_TEMP:
            begin
                norm_off   = '0;
                norm_scale = NORM_MUL_W'(TEMP_SCALE);
            end
            KIND_ACCEL:
            begin
                norm_off   = ACCEL_OFF;
                norm_scale = NORM_MUL_W'(ACCEL_SCALE);
            end
            KIND_GYRO:
            begin
                norm_off   = GYRO_OFF;
                norm_scale = NORM_MUL_W'(GYRO_SCALE);
            end
            default:
            begin
                norm_off   = '0;
                norm_scale = NORM_MUL_W'(LIGHT_SCALE);
            end
        endcase
    end

    assign norm_v = $signed({{2{est_new_reg[DATA_W-1]}}, est_new_reg}) + norm_off;

    always_comb
    begin
        if (nprod_reg < 0)
            biased = nprod_reg + ((kind == KIND_LIGHT) ? BIAS_LIGHT : BIAS_STD);
        else
            biased = nprod_reg;
        if (kind == KIND_LIGHT)
            norm_q = biased >>> (FRAC_BITS + LIGHT_SHIFT);
        else
            norm_q = biased >>> FRAC_BITS;
    end

    assign sat_hi = norm_q > NORM_MAX;
    assign sat_lo = norm_q < NORM_MIN;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                est_mem_reg[i] <= '0;
                cov_mem_reg[i] <= ONE_FX;
            end
        end
        else if (cmd.update && ch_ok)
        begin
            est_mem_reg[idx] <= est_new;
            cov_mem_reg[idx] <= prod_p_reg[FRAC_BITS +: DATA_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.load)
            cnt_reg <= '0;
        else if (cmd.div_step)
            cnt_reg <= cnt_reg + CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ch_reg     <= in_channel;
            sample_reg <= in_sample;
        end
        if (cmd.load)
        begin
            est_reg <= est_rd;
            p_reg   <= p_sat;
            den_reg <= den_sum;
            rem_reg <= REM_W'(p_sat);
            quo_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? trial - REM_W'(den_reg) : trial;
            quo_reg <= {quo_reg[K_W-2:0], trial_ge};
        end
        if (cmd.mul)
        begin
            prod_e_reg <= diff_s * gain_s;
            prod_p_reg <= PP_W'(p_reg) * PP_W'(K_ONE - gain);
        end
        if (cmd.update)
            est_new_reg <= est_new;
        if (cmd.norm)
            nprod_reg <= norm_v * norm_scale;
        if (cmd.finish)
        begin
            out_channel_reg <= ch_reg;
            if (ch_ok)
            begin
                out_estimate_reg  <= est_new_reg;
                out_saturated_reg <= sat_hi || sat_lo;
                if (sat_hi)
                    out_normalized_reg <= NORM_MAX[DATA_W-1:0];
                else if (sat_lo)
                    out_normalized_reg <= NORM_MIN[DATA_W-1:0];
                else
                    out_normalized_reg <= norm_q[DATA_W-1:0];
            end
            else
            begin
                out_estimate_reg   <= '0;
                out_normalized_reg <= '0;
                out_saturated_reg  <= 1'b0;
            end
        end
    end

    assign out_channel    = out_channel_reg;
    assign out_estimate   = out_estimate_reg;
    assign out_normalized = out_normalized_reg;
    assign out_saturated  = out_saturated_reg;

endmodule
